// File: hdl/bsws_pkg.sv
`timescale 1ns / 1ps

package bsws_pkg;

	// field widths of the stream payloads
	localparam int unsigned OP_W     = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned LIMIT_W  = 5;
	localparam int unsigned M_DATA_W = 40;

	// operation codes carried on the input tuser
	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND = 2'd2;

	// status codes carried on the output tuser
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// capacity limit after reset
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

endpackage

// File: hdl/bsws_ram.sv
`timescale 1ns / 1ps

module bsws_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/bounded_stack_with_search.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of data words with a membership search.
// Input channel (s_*): s_tuser carries the operation (push, pop, find),
// s_tdata the value to push or to look for. One transfer is one operation.
// Output channel (m_*): one result per operation; m_tuser carries the status
// (ok, push refused because full, pop on empty), m_tdata the popped value,
// the found flag and the element count after the operation.
// cfg_wr_en/cfg_wr_data write the capacity limit; a limit above DEPTH acts
// as DEPTH. Write it only while no operation is in flight.
// The block works on one operation at a time. Push, the unused code and pop or
// find on an empty stack go from idle straight to the result state; pop reads
// the top entry first, and find reads the stack RAM from the bottom upward, one
// entry per cycle, until a hit or the top entry. m_tvalid rises when the result
// enters the output register. s_tready is high while the block is idle and
// returns in the same cycle as that result enters the output register; the next
// operation may be taken while the previous result still waits there. If the
// receiver stalls, a finished result waits in its own register and s_tready
// stays low until the output register frees up.
// Reset empties the stack and sets the limit to 16; RAM contents are not cleared.

module bounded_stack_with_search #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,  // capacity_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // value
	input  logic [1:0]  s_tuser,      // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,      // popped_value, found, element_count, zero pad
	output logic [1:0]  m_tuser       // status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = (CW > bsws_pkg::LIMIT_W) ? CW : bsws_pkg::LIMIT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]                      state_q;
	logic [bsws_pkg::LIMIT_W-1:0]    limit_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   cnt_m1;
	logic [AW-1:0]                   idx_q;
	bsws_pkg::op_t                   op_q;
	logic [DATA_WIDTH-1:0]           value_q;
	bsws_pkg::status_t               res_status_q;
	logic [DATA_WIDTH-1:0]           res_popped_q;
	logic                            res_found_q;
	logic                            m_tvalid_q;
	bsws_pkg::status_t               out_status_q;
	logic [bsws_pkg::VALUE_W-1:0]    out_popped_q;
	logic                            out_found_q;
	logic [bsws_pkg::COUNT_W-1:0]    out_count_q;

	logic                  s_xfer;
	logic                  full;
	logic                  out_free;
	logic                  wr_en;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  hit;
	logic                  last;
	bsws_pkg::op_t         op_in;

	assign op_in    = s_tuser;
	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cnt_m1   = count_q - CW'(1);

	// full against the limit and against the built-in depth
	assign full = (LW'(count_q) >= LW'(limit_q)) || (count_q >= CW'(DEPTH));

	// push writes the new top at the transfer
	assign wr_en = s_xfer && (op_in == bsws_pkg::OP_PUSH) && !full;

	// read address: top for pop, bottom then upward for find
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q + AW'(1);
		if (state_q == ST_IDLE) begin
			rd_en = s_xfer && (count_q != '0) &&
				(op_in inside {bsws_pkg::OP_POP, bsws_pkg::OP_FIND});
			rd_addr = (op_in == bsws_pkg::OP_POP) ? cnt_m1[AW-1:0] : '0;
		end else if (state_q == ST_SCAN) begin
			rd_en = 1'b1;
		end
	end

	bsws_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(DATA_WIDTH'(s_tdata)),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign hit  = (rd_data == value_q);
	assign last = (idx_q == cnt_m1[AW-1:0]);

	// capacity limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bsws_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// operation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						idx_q <= '0;
						case (op_in)
							bsws_pkg::OP_PUSH: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_FIN;
							end
							bsws_pkg::OP_POP: begin
								if (count_q != '0) begin
									count_q <= cnt_m1;
									state_q <= ST_POP;
								end else begin
									state_q <= ST_FIN;
								end
							end
							bsws_pkg::OP_FIND: begin
								state_q <= (count_q != '0) ? ST_SCAN : ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_POP: begin
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					if (hit || last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			op_q         <= op_in;
			value_q      <= DATA_WIDTH'(s_tdata);
			res_popped_q <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= bsws_pkg::STATUS_OK;
			if ((op_in == bsws_pkg::OP_PUSH) && full) begin
				res_status_q <= bsws_pkg::STATUS_FULL;
			end
			if ((op_in == bsws_pkg::OP_POP) && (count_q == '0)) begin
				res_status_q <= bsws_pkg::STATUS_EMPTY;
			end
		end
		if (state_q == ST_POP) begin
			res_popped_q <= rd_data;
		end
		if ((state_q == ST_SCAN) && hit) begin
			res_found_q <= 1'b1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_status_q <= res_status_q;
			out_popped_q <= bsws_pkg::VALUE_W'(res_popped_q);
			out_found_q  <= res_found_q;
			out_count_q  <= bsws_pkg::COUNT_W'(count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, out_count_q, out_found_q, out_popped_q};

	// count never passes the built-in depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	// count moves only at an input transfer
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_xfer |=> (count_q == $past(count_q)))
		else $error("element count changed without a transfer");

	// scan stays inside the live entries
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(idx_q) < count_q))
		else $error("search index beyond element count");

	// found is only raised by a find
	a_found_op: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && res_found_q) |-> (op_q == bsws_pkg::OP_FIND))
		else $error("found flag on a non-find operation");

endmodule

// File: tb/bounded_stack_with_search_tb.sv
`timescale 1ns / 1ps

module bounded_stack_with_search_tb;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 300000;
	// spare op code, the block treats it as a no-op
	localparam bsws_pkg::op_t OP_NONE = 2'd3;

	// expected contents of one output transfer
	typedef struct {
		bsws_pkg::status_t                status;
		logic [31:0]                      popped;
		logic                             found;
		logic [bsws_pkg::COUNT_W-1:0]     held;
	} stack_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [4:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0] m_tuser;

	// shadow copy of the stack and its limit
	logic [31:0] shadow_stack [STACK_DEPTH];
	int unsigned shadow_count = 0;
	logic [bsws_pkg::LIMIT_W-1:0] shadow_limit = bsws_pkg::LIMIT_RESET;
	stack_result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned ops_done = 0;
	int unsigned pushes_refused = 0;
	int unsigned pops_empty = 0;
	int unsigned finds_hit = 0;
	int unsigned deepest = 0;

	bounded_stack_with_search uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),   // value
		.s_tuser    (s_tuser),   // op
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),   // popped_value, found, element_count, zero pad
		.m_tuser    (m_tuser)    // status
	);

	always #1 clk = ~clk;

	// run time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("bounded_stack_with_search_tb NOT OK");
			$finish;
		end
	end

	// apply one operation to the shadow stack and return its result
	function automatic stack_result_t apply_stack_op(bsws_pkg::op_t op, logic [31:0] value);
		stack_result_t r;
		int unsigned cap;
		int unsigned i;
		r = '{status: bsws_pkg::STATUS_OK, popped: '0, found: 1'b0, held: '0};
		cap = (shadow_limit > STACK_DEPTH) ? STACK_DEPTH : shadow_limit;
		case (op)
			bsws_pkg::OP_PUSH: begin
				if (shadow_count >= cap) begin
					r.status = bsws_pkg::STATUS_FULL;
					pushes_refused++;
				end else begin
					shadow_stack[shadow_count] = value;
					shadow_count++;
				end
			end
			bsws_pkg::OP_POP: begin
				if (shadow_count == 0) begin
					r.status = bsws_pkg::STATUS_EMPTY;
					pops_empty++;
				end else begin
					shadow_count--;
					r.popped = shadow_stack[shadow_count];
				end
			end
			bsws_pkg::OP_FIND: begin
				for (i = 0; i < shadow_count; i++)
					if (shadow_stack[i] == value)
						r.found = 1'b1;
				if (r.found)
					finds_hit++;
			end
			default: ;
		endcase
		r.held = shadow_count[bsws_pkg::COUNT_W-1:0];
		if (shadow_count > deepest)
			deepest = shadow_count;
		ops_done++;
		return r;
	endfunction

	// one input transfer, with random idle cycles ahead of it
	task automatic send_op(input bsws_pkg::op_t op, input logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_stack_op(op, value));
	endtask

	// hold off the sender until every result is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [bsws_pkg::LIMIT_W-1:0] limit);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_limit = limit;
	endtask

	// mostly corner values and small numbers so finds hit often
	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3, 4: return $urandom_range(7);
			default: return $urandom();
		endcase
	endfunction

	// compare each output transfer with the oldest expectation
	task automatic check_result();
		stack_result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result, status %0d tdata %h", $time, m_tuser, m_tdata);
			mismatch_count++;
		end else begin
			want = pending_results.pop_front();
			if (m_tuser !== want.status) begin
				$display("%0t: status expected %0d, actual %0d", $time, want.status, m_tuser);
				mismatch_count++;
			end
			if (m_tdata[31:0] !== want.popped) begin
				$display("%0t: popped_value expected %h, actual %h",
					$time, want.popped, m_tdata[31:0]);
				mismatch_count++;
			end
			if (m_tdata[32] !== want.found) begin
				$display("%0t: found expected %0d, actual %0d", $time, want.found, m_tdata[32]);
				mismatch_count++;
			end
			if (m_tdata[37:33] !== want.held) begin
				$display("%0t: element_count expected %0d, actual %0d",
					$time, want.held, m_tdata[37:33]);
				mismatch_count++;
			end
		end
	endtask

	// receiver: check transfers, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// find, pop and the spare code on a fresh stack
	task automatic test_empty_stack();
		send_op(bsws_pkg::OP_FIND, 32'h0000_0000);
		send_op(bsws_pkg::OP_POP, 32'h0000_1234);
		send_op(OP_NONE, 32'hffff_ffff);
	endtask

	// corner values at both ends of a small stack, push into a full one
	task automatic test_extreme_values();
		write_limit(5'd3);
		send_op(bsws_pkg::OP_PUSH, 32'h8000_0000);
		send_op(bsws_pkg::OP_PUSH, 32'h7fff_ffff);
		send_op(bsws_pkg::OP_PUSH, 32'hffff_ffff);
		send_op(bsws_pkg::OP_PUSH, 32'h0000_0000);
		send_op(bsws_pkg::OP_FIND, 32'h8000_0000);
		send_op(bsws_pkg::OP_FIND, 32'hffff_ffff);
		send_op(bsws_pkg::OP_FIND, 32'h0000_0000);
		send_op(bsws_pkg::OP_FIND, 32'h7fff_fffe);
	endtask

	// limit lowered below the count, limit zero, limit above depth
	task automatic test_limit_changes();
		write_limit(5'd1);
		send_op(bsws_pkg::OP_PUSH, 32'h0000_0001);
		send_op(bsws_pkg::OP_POP, 32'h0000_0000);
		send_op(bsws_pkg::OP_POP, 32'h0000_0000);
		send_op(bsws_pkg::OP_PUSH, 32'h0000_0002);
		send_op(bsws_pkg::OP_POP, 32'h0000_0000);
		send_op(bsws_pkg::OP_POP, 32'h0000_0000);
		send_op(bsws_pkg::OP_PUSH, 32'h0000_0005);
		write_limit(5'd0);
		send_op(bsws_pkg::OP_PUSH, 32'h0000_0006);
		send_op(bsws_pkg::OP_FIND, 32'h0000_0005);
		write_limit(5'd31);
		send_op(bsws_pkg::OP_PUSH, 32'h0000_0006);
		send_op(bsws_pkg::OP_POP, 32'h0000_0000);
		send_op(bsws_pkg::OP_POP, 32'h0000_0000);
	endtask

	// bursts that fill and drain the stack, finds aimed at held values
	task automatic run_random_phase(input int n, input logic [bsws_pkg::LIMIT_W-1:0] limit,
			input int idle_pct, input int stall_pct);
		int k;
		int roll;
		int push_cut;
		bsws_pkg::op_t op;
		logic [31:0] value;
		write_limit(limit);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		push_cut = 80;
		for (k = 0; k < n; k++) begin
			if (k % 40 == 0)
				push_cut = $urandom_range(1) ? 80 : 45;
			roll = $urandom_range(99);
			if (roll < 4)
				op = OP_NONE;
			else if (roll < 24)
				op = bsws_pkg::OP_FIND;
			else if (roll < push_cut)
				op = bsws_pkg::OP_PUSH;
			else
				op = bsws_pkg::OP_POP;
			if (op == bsws_pkg::OP_FIND && shadow_count > 0 && $urandom_range(1))
				value = shadow_stack[$urandom_range(shadow_count - 1)];
			else
				value = pick_value();
			send_op(op, value);
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(110, 5'd16, 0, 0);
		run_random_phase(110, 5'd31, 78, 0);
		run_random_phase(110, 5'd7, 0, 78);
		run_random_phase(110, 5'd12, 26, 26);
		run_random_phase(110, 5'd16, 0, 0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_stack();
		test_extreme_values();
		test_limit_changes();
		test_random_traffic();
		wait_idle();
		repeat (30) @(posedge clk);
		$display("ran %0d stack operations, deepest stack %0d, limits 0 to 31", ops_done, deepest);
		$display("pushes refused %0d, pops on empty %0d, finds that hit %0d",
			pushes_refused, pops_empty, finds_hit);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("bounded_stack_with_search_tb OK");
		end else begin
			$display("bounded_stack_with_search_tb NOT OK");
		end
		$finish;
	end

endmodule
